/* rtl/ohs_pkg.sv */
// ----------------------------------------------------------------------------
// ohs_pkg: shared definitions for the overwriting history stack
// Operation codes, fixed field widths of the word channels and default
// parameter values.
// ----------------------------------------------------------------------------
package ohs_pkg;

   // Fixed payload widths of the request and response words.
   localparam int KIND_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = 5;

   // Defaults for the top-level parameters.
   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Operation codes carried in the kind field. The remaining code does nothing.
   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH = 2'd0,
      KIND_POP  = 2'd1,
      KIND_PEEK = 2'd2
   } kind_type;

endpackage

/* rtl/ohs_req_if.sv */
// ----------------------------------------------------------------------------
// ohs_req_if: request channel of the overwriting history stack
// Carries one operation word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ohs_req_if;

   logic                        valid;
   logic                        ready;
   logic [ohs_pkg::KIND_W-1:0]  kind;
   logic [ohs_pkg::VALUE_W-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);

endinterface

/* rtl/ohs_rsp_if.sv */
// ----------------------------------------------------------------------------
// ohs_rsp_if: response channel of the overwriting history stack
// Carries one result word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ohs_rsp_if;

   logic                        valid;
   logic                        ready;
   logic                        overwrote;
   logic                        found;
   logic [ohs_pkg::DATA_W-1:0]  data;
   logic [ohs_pkg::COUNT_W-1:0] count;

   modport source (output valid, output overwrote, output found, output data,
                   output count, input ready);
   modport sink   (input valid, input overwrote, input found, input data,
                   input count, output ready);

endinterface

/* rtl/overwriting_history_stack.sv */
// ----------------------------------------------------------------------------
// overwriting_history_stack: bounded stack that drops its oldest entry
// A ring of DEPTH words in a synchronous memory used as a stack. A push when
// full overwrites the oldest entry; pop and peek return the newest entry.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake     payload
//   req_if    in         valid/ready   kind, value
//   rsp_if    out        valid/ready   overwrote, found, data, count
//
// One word is accepted per cycle when the response side keeps up; each result
// passes through the registered read of the slot memory and then the output
// register. Reset clears the pointers, the count and both valid flags; the
// slot memory needs no clearing. A stalled response holds the read stage,
// and the request side stalls only once both stages are occupied.

module overwriting_history_stack #(
   parameter int DEPTH      = ohs_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = ohs_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   ohs_req_if.sink      req_if,
   ohs_rsp_if.source    rsp_if
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef struct packed {
      logic             overwrote;
      logic             found;
      logic [CNT_W-1:0] count;
   } meta_type;

   typedef struct packed {
      logic                        overwrote;
      logic                        found;
      logic [ohs_pkg::DATA_W-1:0]  data;
      logic [ohs_pkg::COUNT_W-1:0] count;
   } rsp_type;

   // Slot memory: undefined until written.
   logic [DATA_WIDTH-1:0] slots_mem [DEPTH];

   logic [PTR_W-1:0] oldest_ptr_ff, oldest_ptr_in;
   logic [PTR_W-1:0] next_ptr_ff,   next_ptr_in;
   logic [CNT_W-1:0] held_ff,       held_in;

   logic             s1_valid_ff, s1_valid_in;
   meta_type         s1_meta_ff,  s1_meta_in;
   logic [DATA_WIDTH-1:0] rd_data_ff;

   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff,       out_in;

   logic             out_free, s1_move, accept, do_write, full, empty;
   logic [PTR_W-1:0] next_dec, next_inc, oldest_inc;
   logic [DATA_WIDTH-1:0] word;
   logic [DATA_WIDTH+ohs_pkg::VALUE_W-1:0] value_ext;
   logic [ohs_pkg::DATA_W+DATA_WIDTH-1:0]  rd_ext;
   logic [ohs_pkg::COUNT_W+CNT_W-1:0]      count_ext;

   // Handshake and stage movement.
   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign s1_move      = s1_valid_ff && out_free;
   assign req_if.ready = !s1_valid_ff || out_free;
   assign accept       = req_if.valid && req_if.ready;

   assign full  = (held_ff == CNT_W'(DEPTH));
   assign empty = (held_ff == '0);

   assign next_dec   = (next_ptr_ff == '0) ? PTR_W'(DEPTH - 1) : next_ptr_ff - 1'b1;
   assign next_inc   = (next_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : next_ptr_ff + 1'b1;
   assign oldest_inc = (oldest_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : oldest_ptr_ff + 1'b1;

   assign value_ext = {{DATA_WIDTH{1'b0}}, req_if.value};
   assign word      = value_ext[DATA_WIDTH-1:0];

   // Pointer and count update at acceptance.
   always_comb begin
      oldest_ptr_in        = oldest_ptr_ff;
      next_ptr_in          = next_ptr_ff;
      held_in              = held_ff;
      do_write             = 1'b0;
      s1_meta_in.overwrote = 1'b0;
      s1_meta_in.found     = 1'b0;
      if (accept) begin
         unique case (req_if.kind)
            ohs_pkg::KIND_PUSH: begin
               do_write    = 1'b1;
               next_ptr_in = next_inc;
               if (full) begin
                  // When full the newest end meets the oldest entry.
                  oldest_ptr_in        = oldest_inc;
                  s1_meta_in.overwrote = 1'b1;
               end else begin
                  held_in = held_ff + 1'b1;
               end
            end
            ohs_pkg::KIND_POP: begin
               if (!empty) begin
                  next_ptr_in      = next_dec;
                  held_in          = held_ff - 1'b1;
                  s1_meta_in.found = 1'b1;
               end
            end
            ohs_pkg::KIND_PEEK: begin
               s1_meta_in.found = !empty;
            end
            default: begin
            end
         endcase
      end
      s1_meta_in.count = held_in;
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // Memory: write at the newest end on a push, read below the newest end on
   // every accepted word. Both use the state before the operation, and the
   // write lands before the next word's read samples the array.
   always_ff @(posedge clock) begin
      if (do_write) begin
         slots_mem[next_ptr_ff] <= word;
      end
      if (accept) begin
         rd_data_ff <= slots_mem[next_dec];
         s1_meta_ff <= s1_meta_in;
      end
   end

   assign rd_ext    = {{ohs_pkg::DATA_W{1'b0}}, rd_data_ff};
   assign count_ext = {{ohs_pkg::COUNT_W{1'b0}}, s1_meta_ff.count};

   always_comb begin
      out_in.overwrote = s1_meta_ff.overwrote;
      out_in.found     = s1_meta_ff.found;
      out_in.data      = s1_meta_ff.found ? rd_ext[ohs_pkg::DATA_W-1:0] : '0;
      out_in.count     = count_ext[ohs_pkg::COUNT_W-1:0];
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ptr_ff <= '0;
         next_ptr_ff   <= '0;
         held_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         oldest_ptr_ff <= oldest_ptr_in;
         next_ptr_ff   <= next_ptr_in;
         held_ff       <= held_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.overwrote = out_ff.overwrote;
   assign rsp_if.found     = out_ff.found;
   assign rsp_if.data      = out_ff.data;
   assign rsp_if.count     = out_ff.count;

   // The count never exceeds the ring size.
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_W'(DEPTH))
      else $error("held count exceeds depth");

   // Empty or full rings have both pointers on the same slot.
   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> (next_ptr_ff == oldest_ptr_ff))
      else $error("pointers disagree with held count");

   // A push into a full ring keeps it full and moves the oldest pointer.
   a_overwrite: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.kind == ohs_pkg::KIND_PUSH && full)
      |=> (full && oldest_ptr_ff != $past(oldest_ptr_ff)))
      else $error("overwrite did not advance the oldest entry");

   // A successful pop removes exactly one entry.
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.kind == ohs_pkg::KIND_POP && !empty)
      |=> (held_ff == $past(held_ff) - 1'b1))
      else $error("pop did not decrement the held count");

   // A result word never reports both an overwrite and a returned entry.
   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !(rsp_if.found && rsp_if.overwrote))
      else $error("result word reports overwrite and found together");

endmodule

/* dv/ohs_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ohs_checker: result checker for the overwriting history stack
// Watches both channels, keeps its own copy of the ring and its pointers,
// works out the result of every accepted request and compares each accepted
// response word with the oldest result still awaited.
// ----------------------------------------------------------------------------
module ohs_checker (
   input  logic        clock,
   input  logic        reset,
   ohs_req_if          req_bus,
   ohs_rsp_if          rsp_bus,
   output int unsigned mismatches,
   output int unsigned outstanding
);

   localparam int DEPTH      = ohs_pkg::DEPTH_DEFAULT;
   localparam int DATA_WIDTH = ohs_pkg::DATA_WIDTH_DEFAULT;

   typedef struct packed {
      logic                        overwrote;
      logic                        found;
      logic [ohs_pkg::DATA_W-1:0]  data;
      logic [ohs_pkg::COUNT_W-1:0] count;
   } stack_result_type;

   logic [DATA_WIDTH-1:0] ring_words [DEPTH];
   int                    oldest_idx;
   int                    next_idx;
   int                    entries_held;
   stack_result_type      awaited_results [$];

   task automatic report_error(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   // Applies one operation to the shadow ring and returns the result word it
   // should produce.
   function automatic stack_result_type stack_apply(
      input logic [ohs_pkg::KIND_W-1:0]  op,
      input logic [ohs_pkg::VALUE_W-1:0] word);
      stack_result_type res;
      res = '0;
      case (op)
         ohs_pkg::KIND_PUSH: begin
            if (entries_held >= DEPTH) begin
               // Full: the oldest entry makes way and both ends move on.
               ring_words[oldest_idx] = word[DATA_WIDTH-1:0];
               oldest_idx = (oldest_idx == DEPTH - 1) ? 0 : oldest_idx + 1;
               next_idx   = (next_idx == DEPTH - 1) ? 0 : next_idx + 1;
               res.overwrote = 1'b1;
            end else begin
               ring_words[next_idx] = word[DATA_WIDTH-1:0];
               next_idx = (next_idx == DEPTH - 1) ? 0 : next_idx + 1;
               entries_held++;
            end
         end
         ohs_pkg::KIND_POP: begin
            if (entries_held != 0) begin
               next_idx = (next_idx == 0) ? DEPTH - 1 : next_idx - 1;
               res.data  = ohs_pkg::DATA_W'(ring_words[next_idx]);
               res.found = 1'b1;
               entries_held--;
            end
         end
         ohs_pkg::KIND_PEEK: begin
            if (entries_held != 0) begin
               res.data  = ohs_pkg::DATA_W'(
                  ring_words[(next_idx == 0) ? DEPTH - 1 : next_idx - 1]);
               res.found = 1'b1;
            end
         end
         default: begin
         end
      endcase
      res.count = ohs_pkg::COUNT_W'(entries_held);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      stack_result_type want;
      if (reset) begin
         oldest_idx   = 0;
         next_idx     = 0;
         entries_held = 0;
         awaited_results.delete();
      end else begin
         // The response is handled first: a word requested at this very edge
         // cannot already be on the response side.
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_results.size() == 0) begin
               report_error($sformatf("response word with nothing awaited (data %0h)",
                                      rsp_bus.data));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_bus.overwrote !== want.overwrote)
                  report_error($sformatf("overwrote is %0b, expected %0b",
                                         rsp_bus.overwrote, want.overwrote));
               if (rsp_bus.found !== want.found)
                  report_error($sformatf("found is %0b, expected %0b",
                                         rsp_bus.found, want.found));
               if (rsp_bus.data !== want.data)
                  report_error($sformatf("data is %0h, expected %0h",
                                         rsp_bus.data, want.data));
               if (rsp_bus.count !== want.count)
                  report_error($sformatf("count is %0d, expected %0d",
                                         rsp_bus.count, want.count));
            end
         end
         if (req_bus.valid && req_bus.ready)
            awaited_results.push_back(stack_apply(req_bus.kind, req_bus.value));
      end
      outstanding = awaited_results.size();
   end

endmodule

/* dv/tb_overwriting_history_stack.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_overwriting_history_stack: testbench top for the overwriting history stack
// Drives a directed opening sequence and then bursts of random push, pop and
// peek words under three idling mixes, while a checker beside the block
// predicts and compares every response word.
// ----------------------------------------------------------------------------
module tb_overwriting_history_stack;

   localparam logic [ohs_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int STALL_LIMIT     = 2000;
   localparam int WORDS_PER_PHASE = 600;
   localparam int BURST_LEN       = 20;
   localparam int SEND_IDLE [3]   = '{12, 88, 0};
   localparam int RECV_IDLE [3]   = '{88, 12, 0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned quiet_cycles = 0;
   int unsigned send_idle_pct = SEND_IDLE[0];
   int unsigned recv_idle_pct = RECV_IDLE[0];

   ohs_req_if req_bus ();
   ohs_rsp_if rsp_bus ();

   overwriting_history_stack u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   ohs_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Presents one word and returns at the edge where it is taken. Ready is
   // sampled at the falling edge, where nothing is changing.
   task automatic send_word(input logic [ohs_pkg::KIND_W-1:0]  op,
                            input logic [ohs_pkg::VALUE_W-1:0] word);
      logic taken;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind  <= op;
      req_bus.value <= word;
      do begin
         @(negedge clock);
         taken = req_bus.ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Stops sending and returns at a falling edge once every response is in.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   // Random word whose push share sets whether the ring fills or empties.
   task automatic send_random_word(input int push_pct);
      int                          pick;
      logic [ohs_pkg::VALUE_W-1:0] word;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
         0:       word = '0;
         1:       word = '1;
         default: word = $urandom;
      endcase
      if (pick < 4)
         send_word(KIND_UNUSED, word);
      else if (pick < 4 + push_pct * 96 / 100)
         send_word(ohs_pkg::KIND_PUSH, word);
      else if (pick % 3 == 0)
         send_word(ohs_pkg::KIND_PEEK, word);
      else
         send_word(ohs_pkg::KIND_POP, word);
   endtask

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.kind  <= ohs_pkg::KIND_PUSH;
      req_bus.value <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty ring: pop, peek and the unused code find nothing.
      send_word(ohs_pkg::KIND_POP, 32'h1234_5678);
      send_word(ohs_pkg::KIND_PEEK, 32'hFFFF_FFFF);
      send_word(KIND_UNUSED, 32'hFFFF_FFFF);
      send_word(ohs_pkg::KIND_PUSH, 32'hFFFF_FFFF);
      send_word(ohs_pkg::KIND_PEEK, '0);
      send_word(ohs_pkg::KIND_POP, '0);
      // Fill to the brim, then push once more so the oldest entry is lost.
      for (int i = 0; i < ohs_pkg::DEPTH_DEFAULT; i++)
         send_word(ohs_pkg::KIND_PUSH, (i == 0) ? 32'h0 : $urandom);
      send_word(ohs_pkg::KIND_PUSH, 32'hA5A5_5A5A);
      send_word(KIND_UNUSED, '0);
      send_word(ohs_pkg::KIND_POP, '0);

      for (int phase = 0; phase < 3; phase++) begin
         if (phase > 0) begin
            drain_responses();
            send_idle_pct = SEND_IDLE[phase];
            recv_idle_pct = RECV_IDLE[phase];
            @(posedge clock);
         end
         for (int burst = 0; burst < WORDS_PER_PHASE / BURST_LEN; burst++) begin
            int push_pct;
            case ($urandom_range(0, 2))
               0:       push_pct = 85;
               1:       push_pct = 20;
               default: push_pct = 50;
            endcase
            repeat (BURST_LEN) send_random_word(push_pct);
         end
      end

      drain_responses();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* overwriting_history_stack.f */
rtl/ohs_pkg.sv
rtl/ohs_req_if.sv
rtl/ohs_rsp_if.sv
rtl/overwriting_history_stack.sv
dv/ohs_checker.sv
dv/tb_overwriting_history_stack.sv
